### rtl/timestamped_sample_ring_store_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timestamped sample ring store
// Shorthand for clocked implication checks; clk and rst_n come from the
// scope of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_SAMPLE_RING_STORE_CORE_ASSERT_SVH
`define TIMESTAMPED_SAMPLE_RING_STORE_CORE_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define TSRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsrs check failed in same cycle");

// consequence must hold in the cycle after the antecedent
`define TSRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsrs check failed in next cycle");

`endif

### rtl/tsrs_pkg.sv
// ----------------------------------------------------------------------------
// Timestamped sample ring store package
// Field widths, request and status codes, register indexes and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsrs_pkg;

  // Built ring depth default
  localparam int DEF_RING_DEPTH = 32;

  // Field widths
  localparam int TS_W       = 32;
  localparam int VAL_W      = 32;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int CNT_OUT_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int POLICY_W   = 2;
  localparam int KIND_W     = 2;
  localparam int DEPTH_W    = 6;

  // Smallest usable capacity
  localparam int MIN_CAP = 4;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NEWEST = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  // Result status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd2;

  // Overflow policy codes
  localparam logic [POLICY_W-1:0] POL_DROP   = 2'd0;
  localparam logic [POLICY_W-1:0] POL_REJECT = 2'd1;
  localparam logic [POLICY_W-1:0] POL_MERGE  = 2'd2;

  // Value kind codes
  localparam logic [KIND_W-1:0] KIND_SIGNED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNSIGNED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RAW      = 2'd2;

  typedef logic [2:0] rd_op_t;
  typedef logic [2:0] wr_op_t;
  typedef logic [1:0] ptr_op_t;
  typedef logic [1:0] idx_op_t;
  typedef logic [2:0] out_op_t;

  // Memory read selection
  localparam rd_op_t RD_NONE   = 3'd0;
  localparam rd_op_t RD_NEWEST = 3'd1;
  localparam rd_op_t RD_OLDEST = 3'd2;
  localparam rd_op_t RD_IDX    = 3'd3;
  localparam rd_op_t RD_IDX1   = 3'd4;
  localparam rd_op_t RD_IDX2   = 3'd5;

  // Memory write selection
  localparam wr_op_t WR_NONE   = 3'd0;
  localparam wr_op_t WR_APPEND = 3'd1;
  localparam wr_op_t WR_MERGE  = 3'd2;
  localparam wr_op_t WR_SHIFT  = 3'd3;
  localparam wr_op_t WR_TAIL   = 3'd4;

  // Pointer updates
  localparam ptr_op_t P_NONE   = 2'd0;
  localparam ptr_op_t P_APPEND = 2'd1;
  localparam ptr_op_t P_CLEAR  = 2'd2;

  // Walk index updates
  localparam idx_op_t I_NONE      = 2'd0;
  localparam idx_op_t I_OLD1      = 2'd1;
  localparam idx_op_t I_INC       = 2'd2;
  localparam idx_op_t I_WALK_INIT = 2'd3;

  // Result to emit
  localparam out_op_t O_NONE   = 3'd0;
  localparam out_op_t O_OK     = 3'd1;
  localparam out_op_t O_EMPTY  = 3'd2;
  localparam out_op_t O_FULL   = 3'd3;
  localparam out_op_t O_NEWEST = 3'd4;
  localparam out_op_t O_FINAL  = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    hold_d0;
    logic    walk;
    rd_op_t  rd_op;
    wr_op_t  wr_op;
    ptr_op_t ptr_op;
    idx_op_t idx_op;
    out_op_t out_op;
  } tsrs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pol_reject;
    logic pol_merge;
    logic shift_last;
    logic shift2_last;
    logic walk_done;
  } tsrs_stat_t;

endpackage

### rtl/timestamped_sample_ring_store_core.sv
// ----------------------------------------------------------------------------
// Timestamped sample ring store core
// Ring of timestamped 32-bit samples with insert, read newest, range query
// and clear, and a configurable overflow policy.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every result appears
// for exactly one cycle with out_valid high, in the cycle after the work that
// makes it, and cannot be held off. Insert, clear, reject and read newest on
// an empty ring leave busy low, so a new item may follow in the next cycle.
// A range query walks every stored entry from oldest to newest and gives at
// most one result per cycle. A downsampling insert on a full ring merges the
// two oldest samples, moves each later entry back one place and writes the
// new sample at the tail. The query and the merge shift walk one entry per
// cycle through the single read port of the sample memory.
`timescale 1ns / 1ps
`include "timestamped_sample_ring_store_core_assert.svh"

module timestamped_sample_ring_store_core import tsrs_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [TS_W-1:0]       in_sample_ts,
  input  logic [VAL_W-1:0]      in_sample_value,
  input  logic [TS_W-1:0]       in_range_low,
  input  logic [TS_W-1:0]       in_range_high,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_sample_valid,
  output logic [TS_W-1:0]       out_ts,
  output logic [VAL_W-1:0]      out_value,
  output logic [CNT_OUT_W-1:0]  out_match_count,
  output logic                  out_last_result
);

  tsrs_cmd_t  cmd;
  tsrs_stat_t stat;

  tsrs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .stat        (stat),
    .busy        (busy),
    .cmd         (cmd)
  );

  tsrs_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_sample_ts     (in_sample_ts),
    .in_sample_value  (in_sample_value),
    .in_range_low     (in_range_low),
    .in_range_high    (in_range_high),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_sample_valid (out_sample_valid),
    .out_ts           (out_ts),
    .out_value        (out_value),
    .out_match_count  (out_match_count),
    .out_last_result  (out_last_result)
  );

  // Checks
  // non-final items are query matches carrying a sample
  `TSRS_ASSERT_NOW(a_mid_item_sample, out_valid && !out_last_result, out_sample_valid && (out_status == ST_OK))
  // the final item of any request is shown with the controller back at rest
  `TSRS_ASSERT_NOW(a_last_idle, out_valid && out_last_result, !busy)
  // clear answers in the very next cycle
  `TSRS_ASSERT_NEXT(a_clear_answer, start && !busy && (in_req_type == REQ_CLEAR), out_valid && out_last_result)
  // a match is only reported while a query walk is under way
  `TSRS_ASSERT_NEXT(a_match_in_walk, out_valid && !out_last_result, busy || out_last_result)

endmodule

### rtl/tsrs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/tsrs_datapath.sv
// ----------------------------------------------------------------------------
// Ring store datapath
// Sample memory, ring pointers, configuration registers, merge arithmetic,
// range compare and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsrs_datapath import tsrs_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [TS_W-1:0]       in_sample_ts,
  input  logic [VAL_W-1:0]      in_sample_value,
  input  logic [TS_W-1:0]       in_range_low,
  input  logic [TS_W-1:0]       in_range_high,
  input  tsrs_cmd_t             cmd,
  output tsrs_stat_t            stat,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_sample_valid,
  output logic [TS_W-1:0]       out_ts,
  output logic [VAL_W-1:0]      out_value,
  output logic [CNT_OUT_W-1:0]  out_match_count,
  output logic                  out_last_result
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int MEM_W = TS_W + VAL_W;

  // Wrap-around step helpers against the live capacity
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] top;
    top = c - 1'b1;
    if (CNT_W'(p) == top) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] top;
    top = c - 1'b1;
    if (p == '0) begin
      return top[PTR_W-1:0];
    end
    return p - 1'b1;
  endfunction

  // Halve a two's complement value, rounding toward zero
  function automatic logic [VAL_W-1:0] half_signed(input logic [VAL_W-1:0] x);
    logic [VAL_W-1:0] s;
    s = x + VAL_W'(x[VAL_W-1]);
    return {s[VAL_W-1], s[VAL_W-1:1]};
  endfunction

  // Configuration
  logic [POLICY_W-1:0] policy_r;
  logic [KIND_W-1:0]   kind_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic [CNT_W-1:0]    cap;

  // Ring state and walk state
  logic [PTR_W-1:0] wr_pos_r, old_pos_r, idx_r;
  logic [CNT_W-1:0] fill_r, rem_r, cnt_r;
  logic             pend_r;

  // Latched request and merge operand
  logic [TS_W-1:0]  ts_in_r, lo_r, hi_r, d0_ts_r;
  logic [VAL_W-1:0] val_in_r, d0_val_r;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic                 out_smp_r, out_smp_nxt;
  logic [TS_W-1:0]      out_ts_r, out_ts_nxt;
  logic [VAL_W-1:0]     out_val_r, out_val_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                 out_last_r, out_last_nxt;

  // Memory ports
  logic             rd_en, wr_en;
  logic [PTR_W-1:0] rd_addr, wr_addr;
  logic [MEM_W-1:0] wr_data, rd_data;
  logic [TS_W-1:0]  rd_ts;
  logic [VAL_W-1:0] rd_val;

  logic [PTR_W-1:0] idx_inc, idx_inc2, wr_dec;
  logic [TS_W-1:0]  mrg_ts;
  logic [VAL_W-1:0] mrg_val;
  logic             walk_rd, hit;

  assign rd_ts  = rd_data[MEM_W-1:VAL_W];
  assign rd_val = rd_data[VAL_W-1:0];

  // Capacity clamped to the built range
  always_comb begin
    priority if (depth_r < DEPTH_W'(MIN_CAP)) begin
      cap = CNT_W'(MIN_CAP);
    end else if (depth_r > DEPTH_W'(RING_DEPTH)) begin
      cap = CNT_W'(RING_DEPTH);
    end else begin
      cap = depth_r[CNT_W-1:0];
    end
  end

  assign idx_inc  = ptr_inc(idx_r, cap);
  assign idx_inc2 = ptr_inc(idx_inc, cap);
  assign wr_dec   = ptr_dec(wr_pos_r, cap);

  // Status towards the controller
  assign stat.full        = (fill_r == cap);
  assign stat.empty       = (fill_r == '0);
  assign stat.pol_reject  = (policy_r == POL_REJECT);
  assign stat.pol_merge   = (policy_r == POL_MERGE);
  assign stat.shift_last  = (idx_inc == wr_pos_r);
  assign stat.shift2_last = (idx_inc2 == wr_pos_r);
  assign stat.walk_done   = (rem_r == '0) && !pend_r;

  // Merge of the two oldest samples
  always_comb begin
    mrg_ts = (d0_ts_r >> 1) + (rd_ts >> 1);
    unique case (kind_r)
      KIND_SIGNED:   mrg_val = half_signed(d0_val_r) + half_signed(rd_val);
      KIND_UNSIGNED: mrg_val = (d0_val_r >> 1) + (rd_val >> 1);
      default:       mrg_val = d0_val_r;
    endcase
  end

  // Read address selection
  assign walk_rd = cmd.walk && (rem_r != '0);

  always_comb begin
    rd_en   = walk_rd;
    rd_addr = idx_r;
    unique case (cmd.rd_op)
      RD_NEWEST: begin
        rd_en   = 1'b1;
        rd_addr = wr_dec;
      end
      RD_OLDEST: begin
        rd_en   = 1'b1;
        rd_addr = old_pos_r;
      end
      RD_IDX: begin
        rd_en   = 1'b1;
        rd_addr = idx_r;
      end
      RD_IDX1: begin
        rd_en   = 1'b1;
        rd_addr = idx_inc;
      end
      RD_IDX2: begin
        rd_en   = 1'b1;
        rd_addr = idx_inc2;
      end
      default: ;
    endcase
  end

  // Write address and data selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_pos_r;
    wr_data = {in_sample_ts, in_sample_value};
    unique case (cmd.wr_op)
      WR_APPEND: begin
        wr_en = 1'b1;
      end
      WR_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = old_pos_r;
        wr_data = {mrg_ts, mrg_val};
      end
      WR_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data;
      end
      WR_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = wr_dec;
        wr_data = {ts_in_r, val_in_r};
      end
      default: ;
    endcase
  end

  tsrs_ram #(
    .WIDTH (MEM_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Range compare on the sample read in the previous walk cycle
  assign hit = pend_r && (lo_r <= hi_r) && (rd_ts >= lo_r) && (rd_ts <= hi_r);

  // Result selection
  always_comb begin
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_smp_nxt    = 1'b0;
    out_ts_nxt     = '0;
    out_val_nxt    = '0;
    out_cnt_nxt    = '0;
    out_last_nxt   = 1'b1;
    unique case (cmd.out_op)
      O_OK: begin
        out_valid_nxt = 1'b1;
      end
      O_EMPTY: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_EMPTY;
      end
      O_FULL: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_FULL;
      end
      O_NEWEST: begin
        out_valid_nxt = 1'b1;
        out_smp_nxt   = 1'b1;
        out_ts_nxt    = rd_ts;
        out_val_nxt   = rd_val;
      end
      O_FINAL: begin
        out_valid_nxt = 1'b1;
        out_cnt_nxt   = CNT_OUT_W'(cnt_r);
      end
      default: ;
    endcase
    // a query match is never emitted alongside another result
    if (hit) begin
      out_valid_nxt = 1'b1;
      out_smp_nxt   = 1'b1;
      out_ts_nxt    = rd_ts;
      out_val_nxt   = rd_val;
      out_last_nxt  = 1'b0;
    end
  end

  // Configuration registers and ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= POL_DROP;
      kind_r    <= KIND_SIGNED;
      depth_r   <= DEPTH_W'(32);
      wr_pos_r  <= '0;
      old_pos_r <= '0;
      fill_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_POLICY: policy_r <= cfg_wdata[POLICY_W-1:0];
        CFG_KIND:   kind_r   <= cfg_wdata[KIND_W-1:0];
        CFG_DEPTH: begin
          depth_r   <= cfg_wdata[DEPTH_W-1:0];
          wr_pos_r  <= '0;
          old_pos_r <= '0;
          fill_r    <= '0;
        end
        default: ;
      endcase
    end else begin
      unique case (cmd.ptr_op)
        P_APPEND: begin
          wr_pos_r <= ptr_inc(wr_pos_r, cap);
          if (fill_r < cap) begin
            fill_r <= fill_r + 1'b1;
          end else begin
            old_pos_r <= ptr_inc(old_pos_r, cap);
          end
        end
        P_CLEAR: begin
          wr_pos_r  <= '0;
          old_pos_r <= '0;
          fill_r    <= '0;
        end
        default: ;
      endcase
    end
  end

  // Walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= walk_rd;
    end
  end

  // Walk index, remaining count and match count
  always_ff @(posedge clk) begin
    unique case (cmd.idx_op)
      I_OLD1: idx_r <= ptr_inc(old_pos_r, cap);
      I_INC:  idx_r <= idx_inc;
      I_WALK_INIT: begin
        idx_r <= old_pos_r;
        rem_r <= fill_r;
        cnt_r <= '0;
      end
      default: ;
    endcase
    if (walk_rd) begin
      idx_r <= idx_inc;
      rem_r <= rem_r - 1'b1;
    end
    if (hit) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Request operands and merge hold register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ts_in_r  <= in_sample_ts;
      val_in_r <= in_sample_value;
      lo_r     <= in_range_low;
      hi_r     <= in_range_high;
    end
    if (cmd.hold_d0) begin
      d0_ts_r  <= rd_ts;
      d0_val_r <= rd_val;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_smp_r    <= out_smp_nxt;
    out_ts_r     <= out_ts_nxt;
    out_val_r    <= out_val_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_sample_valid = out_smp_r;
  assign out_ts           = out_ts_r;
  assign out_value        = out_val_r;
  assign out_match_count  = out_cnt_r;
  assign out_last_result  = out_last_r;

endmodule

### rtl/tsrs_ctrl.sv
// ----------------------------------------------------------------------------
// Ring store controller
// Sequences insert, read newest, range query, clear and the downsampling
// merge and shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsrs_ctrl import tsrs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [REQ_W-1:0] in_req_type,
  input  tsrs_stat_t       stat,
  output logic             busy,
  output tsrs_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_NEWEST  = 3'd1;
  localparam logic [2:0] S_WALK    = 3'd2;
  localparam logic [2:0] S_M_RD1   = 3'd3;
  localparam logic [2:0] S_M_MERGE = 3'd4;
  localparam logic [2:0] S_M_SHIFT = 3'd5;
  localparam logic [2:0] S_M_TAIL  = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.hold_d0 = 1'b0;
    cmd.walk    = 1'b0;
    cmd.rd_op   = RD_NONE;
    cmd.wr_op   = WR_NONE;
    cmd.ptr_op  = P_NONE;
    cmd.idx_op  = I_NONE;
    cmd.out_op  = O_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_req_type)
            REQ_INSERT: begin
              priority if (stat.full && stat.pol_reject) begin
                cmd.out_op = O_FULL;
              end else if (stat.full && stat.pol_merge) begin
                cmd.load   = 1'b1;
                cmd.rd_op  = RD_OLDEST;
                cmd.idx_op = I_OLD1;
                state_nxt  = S_M_RD1;
              end else begin
                cmd.wr_op  = WR_APPEND;
                cmd.ptr_op = P_APPEND;
                cmd.out_op = O_OK;
              end
            end
            REQ_NEWEST: begin
              if (stat.empty) begin
                cmd.out_op = O_EMPTY;
              end else begin
                cmd.rd_op = RD_NEWEST;
                state_nxt = S_NEWEST;
              end
            end
            REQ_QUERY: begin
              cmd.load   = 1'b1;
              cmd.idx_op = I_WALK_INIT;
              state_nxt  = S_WALK;
            end
            REQ_CLEAR: begin
              cmd.ptr_op = P_CLEAR;
              cmd.out_op = O_OK;
            end
          endcase
        end
      end
      S_NEWEST: begin
        cmd.out_op = O_NEWEST;
        state_nxt  = S_IDLE;
      end
      // one read issued per cycle, each compared in the cycle after
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          cmd.out_op = O_FINAL;
          state_nxt  = S_IDLE;
        end
      end
      S_M_RD1: begin
        cmd.hold_d0 = 1'b1;
        cmd.rd_op   = RD_IDX;
        state_nxt   = S_M_MERGE;
      end
      S_M_MERGE: begin
        cmd.wr_op = WR_MERGE;
        if (stat.shift_last) begin
          state_nxt = S_M_TAIL;
        end else begin
          cmd.rd_op = RD_IDX1;
          state_nxt = S_M_SHIFT;
        end
      end
      // move each later entry back one place
      S_M_SHIFT: begin
        cmd.wr_op  = WR_SHIFT;
        cmd.idx_op = I_INC;
        if (stat.shift2_last) begin
          state_nxt = S_M_TAIL;
        end else begin
          cmd.rd_op = RD_IDX2;
        end
      end
      S_M_TAIL: begin
        cmd.wr_op  = WR_TAIL;
        cmd.out_op = O_OK;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the timestamped sample ring store core
// Walks a short directed script and then random phases of insert, read
// newest, range query and clear items. Every item is checked against a typed
// result or a local prediction of the ring, and the configuration changes between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tsrs_pkg::*;

  localparam int RING_SLOTS   = DEF_RING_DEPTH;
  localparam int RANDOM_ITEMS = 255;
  localparam int IDLE_WAIT    = 4;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 400000;

  // Codes with no name in the package
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [POLICY_W-1:0]  POL_SPARE  = 2'd3;
  localparam logic [KIND_W-1:0]    KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [TS_W-1:0]  ts;
    logic [VAL_W-1:0] val;
    logic [TS_W-1:0]  lo;
    logic [TS_W-1:0]  hi;
  } ring_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 sample_valid;
    logic [TS_W-1:0]      ts;
    logic [VAL_W-1:0]     value;
    logic [CNT_OUT_W-1:0] count;
    logic                 last;
  } ring_res_t;

  // One line of the directed script: a register write or an item,
  // optionally with its result typed in
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    ring_req_t             rq;
    logic                  known;
    ring_res_t             res;
  } script_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  start;
  logic                  busy;
  logic [REQ_W-1:0]      in_req_type;
  logic [TS_W-1:0]       in_sample_ts;
  logic [VAL_W-1:0]      in_sample_value;
  logic [TS_W-1:0]       in_range_low;
  logic [TS_W-1:0]       in_range_high;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_sample_valid;
  logic [TS_W-1:0]       out_ts;
  logic [VAL_W-1:0]      out_value;
  logic [CNT_OUT_W-1:0]  out_match_count;
  logic                  out_last_result;

  timestamped_sample_ring_store_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_sample_ts     (in_sample_ts),
    .in_sample_value  (in_sample_value),
    .in_range_low     (in_range_low),
    .in_range_high    (in_range_high),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_sample_valid (out_sample_valid),
    .out_ts           (out_ts),
    .out_value        (out_value),
    .out_match_count  (out_match_count),
    .out_last_result  (out_last_result)
  );

  // Predicted ring contents, pointers and registers
  logic [TS_W-1:0]     ring_ts  [RING_SLOTS];
  logic [VAL_W-1:0]    ring_val [RING_SLOTS];
  int unsigned         wr_ptr;
  int unsigned         old_ptr;
  int unsigned         fill;
  logic [POLICY_W-1:0] pol;
  logic [KIND_W-1:0]   kind;
  logic [DEPTH_W-1:0]  depth_reg;

  ring_res_t   awaited_results [$];
  ring_res_t   step_results [$];
  script_row_t script_rows [$];
  ring_res_t   head_res;
  logic [TS_W-1:0] ts_clock;

  int unsigned cycles;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned requests;
  int unsigned inserts;
  int unsigned queries;
  int unsigned merges;
  int unsigned rejects;
  int unsigned cfg_writes;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic ring_res_t mk_res(logic [STATUS_W-1:0] st, logic sv, logic [TS_W-1:0] ts,
                                       logic [VAL_W-1:0] val, logic [CNT_OUT_W-1:0] cnt,
                                       logic last);
    ring_res_t r;
    r.status       = st;
    r.sample_valid = sv;
    r.ts           = ts;
    r.value        = val;
    r.count        = cnt;
    r.last         = last;
    return r;
  endfunction

  function automatic ring_req_t mk_req(logic [REQ_W-1:0] req, logic [TS_W-1:0] ts,
                                       logic [VAL_W-1:0] val, logic [TS_W-1:0] lo,
                                       logic [TS_W-1:0] hi);
    ring_req_t r;
    r.req = req;
    r.ts  = ts;
    r.val = val;
    r.lo  = lo;
    r.hi  = hi;
    return r;
  endfunction

  // Capacity in use: clamped to 4..built depth
  function automatic int unsigned ring_cap();
    int unsigned c;
    c = 32'(depth_reg);
    if (c < MIN_CAP) c = MIN_CAP;
    if (c > RING_SLOTS) c = RING_SLOTS;
    return c;
  endfunction

  // Signed halving that truncates toward zero
  function automatic logic [VAL_W-1:0] halve_to_zero(logic [VAL_W-1:0] x);
    logic [VAL_W-1:0] mag;
    if (!x[VAL_W-1]) return x >> 1;
    mag = (~x + 1'b1) >> 1;
    return ~mag + 1'b1;
  endfunction

  task automatic reset_prediction();
    foreach (ring_ts[i]) begin
      ring_ts[i]  = '0;
      ring_val[i] = '0;
    end
    wr_ptr    = 0;
    old_ptr   = 0;
    fill      = 0;
    pol       = POL_DROP;
    kind      = KIND_SIGNED;
    depth_reg = DEPTH_W'(RING_SLOTS);
  endtask

  task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_POLICY: pol  = data[POLICY_W-1:0];
      CFG_KIND:   kind = data[KIND_W-1:0];
      CFG_DEPTH: begin
        // a capacity change empties the ring
        depth_reg = data;
        wr_ptr    = 0;
        old_ptr   = 0;
        fill      = 0;
      end
      default: ; // unknown index: no effect
    endcase
  endtask

  // Fold the two oldest samples into one and close the gap behind them
  task automatic merge_oldest_pair(int unsigned cap);
    int unsigned i0, i1, head, idx, nx;
    i0   = old_ptr % cap;
    i1   = (i0 + 1) % cap;
    head = wr_ptr % cap;
    ring_ts[i0] = (ring_ts[i0] >> 1) + (ring_ts[i1] >> 1);
    if (kind == KIND_SIGNED)
      ring_val[i0] = halve_to_zero(ring_val[i0]) + halve_to_zero(ring_val[i1]);
    else if (kind == KIND_UNSIGNED)
      ring_val[i0] = (ring_val[i0] >> 1) + (ring_val[i1] >> 1);
    idx = i1;
    nx  = (idx + 1) % cap;
    while (idx != head && nx != head) begin
      ring_ts[idx]  = ring_ts[nx];
      ring_val[idx] = ring_val[nx];
      idx = nx;
      nx  = (idx + 1) % cap;
    end
    wr_ptr = (head + cap - 1) % cap;
    if (fill > 0) fill--;
    merges++;
  endtask

  // Updates the predicted ring for one item and lists its results
  task automatic predict_request(ring_req_t rq);
    int unsigned cap, idx, n, k;
    cap = ring_cap();
    case (rq.req)
      REQ_INSERT: begin
        inserts++;
        if (fill >= cap && pol == POL_REJECT) begin
          rejects++;
          step_results.push_back(mk_res(ST_FULL, 1'b0, '0, '0, '0, 1'b1));
        end else begin
          if (fill >= cap && pol == POL_MERGE) merge_oldest_pair(cap);
          idx = wr_ptr % cap;
          ring_ts[idx]  = rq.ts;
          ring_val[idx] = rq.val;
          wr_ptr = (idx + 1) % cap;
          if (fill < cap) fill++;
          else old_ptr = (old_ptr + 1) % cap;
          step_results.push_back(mk_res(ST_OK, 1'b0, '0, '0, '0, 1'b1));
        end
      end
      REQ_NEWEST: begin
        if (fill == 0) begin
          step_results.push_back(mk_res(ST_EMPTY, 1'b0, '0, '0, '0, 1'b1));
        end else begin
          idx = (wr_ptr % cap + cap - 1) % cap;
          step_results.push_back(mk_res(ST_OK, 1'b1, ring_ts[idx], ring_val[idx], '0, 1'b1));
        end
      end
      REQ_QUERY: begin
        // oldest to newest; an inverted range matches nothing
        queries++;
        idx = old_ptr % cap;
        n   = (fill > cap) ? cap : fill;
        k   = 0;
        for (int i = 0; i < n; i++) begin
          if (rq.lo <= rq.hi && ring_ts[idx] >= rq.lo && ring_ts[idx] <= rq.hi) begin
            step_results.push_back(mk_res(ST_OK, 1'b1, ring_ts[idx], ring_val[idx], '0, 1'b0));
            k++;
          end
          idx = (idx + 1) % cap;
        end
        step_results.push_back(mk_res(ST_OK, 1'b0, '0, '0, k[CNT_OUT_W-1:0], 1'b1));
      end
      REQ_CLEAR: begin
        wr_ptr  = 0;
        old_ptr = 0;
        fill    = 0;
        step_results.push_back(mk_res(ST_OK, 1'b0, '0, '0, '0, 1'b1));
      end
    endcase
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result with nothing outstanding: ts 0x%0h count %0d", out_ts,
               out_match_count);
        mismatches++;
      end else begin
        head_res = awaited_results.pop_front();
        results_checked++;
        check_field("status", 32'(head_res.status), 32'(out_status));
        check_field("sample_valid", 32'(head_res.sample_valid), 32'(out_sample_valid));
        check_field("ts", head_res.ts, out_ts);
        check_field("value", head_res.value, out_value);
        check_field("match_count", 32'(head_res.count), 32'(out_match_count));
        check_field("last_result", 32'(head_res.last), 32'(out_last_result));
      end
    end
  end

  // Entered and left at a falling edge; start stays high after the item
  task automatic push_item(ring_req_t rq, int unsigned gap, logic known, ring_res_t kres);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    in_req_type     <= rq.req;
    in_sample_ts    <= rq.ts;
    in_sample_value <= rq.val;
    in_range_low    <= rq.lo;
    in_range_high   <= rq.hi;
    do @(posedge clk); while (busy !== 1'b0);
    step_results.delete();
    predict_request(rq);
    if (known) awaited_results.push_back(kres);
    else foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    requests++;
    @(negedge clk);
  endtask

  // Drop start and wait for every outstanding result, then a short pause
  task automatic settle(int unsigned extra);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    apply_write(idx, data);
    cfg_writes++;
    @(negedge clk);
  endtask

  function automatic void add_item(ring_req_t rq);
    script_row_t r;
    r        = '0;
    r.rq     = rq;
    script_rows.push_back(r);
  endfunction

  function automatic void add_known(ring_req_t rq, ring_res_t res);
    script_row_t r;
    r        = '0;
    r.rq     = rq;
    r.known  = 1'b1;
    r.res    = res;
    script_rows.push_back(r);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    script_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    script_rows.push_back(r);
  endfunction

  // Timestamps mostly climb slowly so that queries near the present hit
  function automatic ring_req_t random_req();
    ring_req_t   rq;
    int unsigned pick;
    rq.ts  = $urandom;
    rq.val = $urandom;
    rq.lo  = $urandom;
    rq.hi  = $urandom;
    pick   = $urandom_range(0, 99);
    if (pick < 62) begin
      rq.req = REQ_INSERT;
      if ($urandom_range(0, 9) != 0) begin
        ts_clock = ts_clock + $urandom_range(0, 40);
        rq.ts    = ts_clock;
      end
    end else if (pick < 74) begin
      rq.req = REQ_NEWEST;
    end else if (pick < 97) begin
      rq.req = REQ_QUERY;
      case ($urandom_range(0, 9))
        0: ; // fully random bounds
        1: begin
          rq.lo = '0;
          rq.hi = '1;
        end
        2: begin
          // inverted window
          rq.hi = ts_clock - $urandom_range(0, 300);
          rq.lo = rq.hi + $urandom_range(1, 300);
        end
        default: begin
          rq.lo = ts_clock - $urandom_range(0, 600);
          rq.hi = rq.lo + $urandom_range(0, 500);
        end
      endcase
    end else begin
      rq.req = REQ_CLEAR;
    end
    return rq;
  endfunction

  // New register settings between random phases
  task automatic random_setup();
    logic [CFG_DATA_W-1:0] d;
    settle(IDLE_WAIT);
    write_reg(CFG_POLICY, CFG_DATA_W'($urandom_range(0, 63)));
    write_reg(CFG_KIND, CFG_DATA_W'($urandom_range(0, 63)));
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 5))
        0:       d = CFG_DATA_W'($urandom_range(0, MIN_CAP));
        1:       d = CFG_DATA_W'(RING_SLOTS);
        2:       d = CFG_DATA_W'($urandom_range(RING_SLOTS + 1, 63));
        default: d = CFG_DATA_W'($urandom_range(MIN_CAP + 1, 10));
      endcase
      write_reg(CFG_DEPTH, d);
    end
    if ($urandom_range(0, 5) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 63)));
  endtask

  // Directed script
  task automatic build_script();
    add_known(mk_req(REQ_NEWEST, '0, '0, '0, '0), mk_res(ST_EMPTY, 1'b0, '0, '0, '0, 1'b1));
    add_known(mk_req(REQ_QUERY, '0, '0, '0, '1), mk_res(ST_OK, 1'b0, '0, '0, '0, 1'b1));
    add_known(mk_req(REQ_INSERT, '0, '0, '0, '0), mk_res(ST_OK, 1'b0, '0, '0, '0, 1'b1));
    add_known(mk_req(REQ_INSERT, '1, '1, '0, '0), mk_res(ST_OK, 1'b0, '0, '0, '0, 1'b1));
    add_known(mk_req(REQ_NEWEST, '0, '0, '0, '0), mk_res(ST_OK, 1'b1, '1, '1, '0, 1'b1));
    add_item(mk_req(REQ_QUERY, '0, '0, '0, '1));
    // inverted range: nothing matches
    add_known(mk_req(REQ_QUERY, '0, '0, '1, '0), mk_res(ST_OK, 1'b0, '0, '0, '0, 1'b1));
    add_item(mk_req(REQ_QUERY, '0, '0, '1, '1));
    add_known(mk_req(REQ_CLEAR, '1, '1, '1, '1), mk_res(ST_OK, 1'b0, '0, '0, '0, 1'b1));
    add_known(mk_req(REQ_NEWEST, '0, '0, '0, '0), mk_res(ST_EMPTY, 1'b0, '0, '0, '0, 1'b1));
    // capacity below the minimum acts as 4; unknown index is ignored
    add_write(CFG_DEPTH, '0);
    add_write(CFG_UNUSED, '1);
    add_write(CFG_POLICY, CFG_DATA_W'(POL_REJECT));
    add_item(mk_req(REQ_INSERT, 32'd100, 32'hFFFF_FFFF, '0, '0));
    add_item(mk_req(REQ_INSERT, 32'd200, 32'h8000_0000, '0, '0));
    add_item(mk_req(REQ_INSERT, 32'd300, 32'h7FFF_FFFF, '0, '0));
    add_item(mk_req(REQ_INSERT, 32'd400, 32'h0000_0003, '0, '0));
    add_known(mk_req(REQ_INSERT, 32'd500, 32'd1, '0, '0),
              mk_res(ST_FULL, 1'b0, '0, '0, '0, 1'b1));
    add_item(mk_req(REQ_QUERY, '0, '0, '0, '1));
    // full-ring merges under each value kind
    add_write(CFG_POLICY, CFG_DATA_W'(POL_MERGE));
    add_item(mk_req(REQ_INSERT, 32'd600, 32'h8000_0001, '0, '0));
    add_item(mk_req(REQ_QUERY, '0, '0, '0, '1));
    add_write(CFG_KIND, CFG_DATA_W'(KIND_UNSIGNED));
    add_item(mk_req(REQ_INSERT, 32'd700, 32'hFFFF_FFFE, '0, '0));
    add_write(CFG_KIND, CFG_DATA_W'(KIND_RAW));
    add_item(mk_req(REQ_INSERT, 32'd800, 32'h1234_5678, '0, '0));
    add_write(CFG_KIND, {4'hF, KIND_SPARE});
    add_item(mk_req(REQ_INSERT, 32'd900, 32'hAAAA_AAAA, '0, '0));
    add_item(mk_req(REQ_QUERY, '0, '0, '0, '1));
    // spare policy code drops the oldest
    add_write(CFG_POLICY, {4'hF, POL_SPARE});
    add_item(mk_req(REQ_INSERT, '1, 32'h5555_5555, '0, '0));
    add_item(mk_req(REQ_QUERY, '0, '0, 32'd700, 32'hFFFF_FFFE));
    // capacity above the built depth, and the ring is emptied
    add_write(CFG_DEPTH, '1);
    add_known(mk_req(REQ_NEWEST, '0, '0, '0, '0), mk_res(ST_EMPTY, 1'b0, '0, '0, '0, 1'b1));
    add_write(CFG_POLICY, CFG_DATA_W'(POL_MERGE));
    add_write(CFG_KIND, CFG_DATA_W'(KIND_SIGNED));
    add_write(CFG_DEPTH, CFG_DATA_W'(RING_SLOTS));
  endtask

  initial begin
    int unsigned done_random;
    int unsigned phase_len;
    logic        burst;

    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_POLICY;
    cfg_wdata       = '0;
    start           = 1'b0;
    in_req_type     = REQ_INSERT;
    in_sample_ts    = '0;
    in_sample_value = '0;
    in_range_low    = '0;
    in_range_high   = '0;
    cycles          = 0;
    mismatches      = 0;
    results_checked = 0;
    requests        = 0;
    inserts         = 0;
    queries         = 0;
    merges          = 0;
    rejects         = 0;
    cfg_writes      = 0;
    done_random     = 0;
    ts_clock        = $urandom_range(1000, 100000);
    reset_prediction();
    build_script();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (script_rows[i]) begin
      if (script_rows[i].is_cfg) begin
        settle(IDLE_WAIT);
        write_reg(script_rows[i].idx, script_rows[i].data);
      end else begin
        push_item(script_rows[i].rq, $urandom_range(0, 8), script_rows[i].known,
                  script_rows[i].res);
      end
    end

    // random phases; some run back to back with no gaps
    while (done_random < RANDOM_ITEMS) begin
      burst     = ($urandom_range(0, 2) == 0);
      phase_len = (ring_cap() >= 16) ? 60 : 16;
      for (int i = 0; i < phase_len && done_random < RANDOM_ITEMS; i++) begin
        push_item(random_req(), burst ? 0 : $urandom_range(0, 8), 1'b0, '0);
        done_random++;
      end
      if (done_random < RANDOM_ITEMS) random_setup();
    end

    settle(TAIL_CYCLES);

    $display("covered %0d items: %0d inserts, %0d queries, %0d merges, %0d rejects",
             requests, inserts, queries, merges, rejects);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             cfg_writes, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
